FILE: src/ctot_pkg.sv
// Shared types and constants for the circle / triangle overlap test.
// No dependencies; every other file in src depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package ctot_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 15;
  localparam int R2_BITS        = 2 * RADIUS_BITS;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } ctot_cfg_reg_t;

  // Per-stage load enables handed from the top level to each edge unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } ctot_stage_en_t;

endpackage

`default_nettype wire

FILE: src/ctot_if.sv
// Channel interfaces: triangle input, hit result and configuration write.
// Depends on ctot_pkg for the register index width.
`timescale 1ns / 1ps
`default_nettype none

interface ctot_tri_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    output ready
  );
endinterface

interface ctot_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface ctot_cfg_if #(parameter int DATA_W = 16);
  logic                          valid;
  logic                          ready;
  logic [ctot_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/circle_triangle_overlap_test_top.sv
// Top level of the circle / triangle overlap test: config, pipeline control, result.
// Depends on ctot_pkg, ctot_if and ctot_edge.
//
//  channel   | dir | payload                                  | transfer when
//  ----------+-----+------------------------------------------+------------------
//  triangle  | in  | vertex_{a,b,c}_{x,y}, COORD_BITS signed  | valid & ready
//  result    | out | hit, 1 bit                               | valid & ready
//  cfg       | in  | index (centre x, centre y, radius), data | valid & ready
//
// One triangle per cycle sustained while result.ready is high; each triangle passes
// through six register stages (offsets, products, sums, partial products, squares,
// result register).
// Each stage holds only when it is full and the one after it holds, so a
// stalled result does not block input until every stage is full.
// rst clears the stage valid bits and the circle registers; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module circle_triangle_overlap_test_top
  import ctot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ctot_tri_if.sink   triangle,
  ctot_hit_if.source result,
  ctot_cfg_if.sink   cfg
);

  localparam int NSTAGE = 6;

  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;
  logic        [R2_BITS-1:0]     r2;

  logic [NSTAGE:1] stage_valid;
  logic [NSTAGE:1] adv;
  ctot_stage_en_t  en;

  logic [2:0] vin, nonneg, edge_ok;
  logic       hit, hit_next;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
    end else if (cfg.valid) begin
      unique case (ctot_cfg_reg_t'(cfg.index))
        CFG_CENTER_X: center_x <= cfg.data[COORD_BITS-1:0];
        CFG_CENTER_Y: center_y <= cfg.data[COORD_BITS-1:0];
        CFG_RADIUS:   radius   <= cfg.data[RADIUS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_BITS'(radius) * R2_BITS'(radius);
  end

  // stage control: advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NSTAGE] = !stage_valid[NSTAGE] || result.ready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      adv[i] = !stage_valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[1]) begin
        stage_valid[1] <= triangle.valid;
      end
      for (int i = 2; i <= NSTAGE; i++) begin
        if (adv[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign triangle.ready = adv[1];

  always_comb begin
    en.s1 = adv[1];
    en.s2 = adv[2];
    en.s3 = adv[3];
    en.s4 = adv[4];
    en.s5 = adv[5];
  end

  ctot_edge #(.COORD_BITS(COORD_BITS)) u_edge_ab (
    .clk      (clk),
    .en       (en),
    .center_x (center_x),
    .center_y (center_y),
    .r2       (r2),
    .px       (triangle.vertex_a_x),
    .py       (triangle.vertex_a_y),
    .qx       (triangle.vertex_b_x),
    .qy       (triangle.vertex_b_y),
    .vin      (vin[0]),
    .nonneg   (nonneg[0]),
    .edge_ok  (edge_ok[0])
  );

  ctot_edge #(.COORD_BITS(COORD_BITS)) u_edge_bc (
    .clk      (clk),
    .en       (en),
    .center_x (center_x),
    .center_y (center_y),
    .r2       (r2),
    .px       (triangle.vertex_b_x),
    .py       (triangle.vertex_b_y),
    .qx       (triangle.vertex_c_x),
    .qy       (triangle.vertex_c_y),
    .vin      (vin[1]),
    .nonneg   (nonneg[1]),
    .edge_ok  (edge_ok[1])
  );

  ctot_edge #(.COORD_BITS(COORD_BITS)) u_edge_ca (
    .clk      (clk),
    .en       (en),
    .center_x (center_x),
    .center_y (center_y),
    .r2       (r2),
    .px       (triangle.vertex_c_x),
    .py       (triangle.vertex_c_y),
    .qx       (triangle.vertex_a_x),
    .qy       (triangle.vertex_a_y),
    .vin      (vin[2]),
    .nonneg   (nonneg[2]),
    .edge_ok  (edge_ok[2])
  );

  // any vertex inside, centre on the non-negative side of every edge, or an edge crossing
  assign hit_next = (|vin) || (&nonneg) || (|edge_ok);

  always_ff @(posedge clk) begin
    if (adv[NSTAGE]) begin
      hit <= hit_next;
    end
  end

  assign result.valid = stage_valid[NSTAGE];
  assign result.hit   = hit;

endmodule

`default_nettype wire

FILE: src/ctot_edge.sv
// One vertex / edge slice of the overlap pipeline (stages one to five).
// Depends on ctot_pkg; instantiated three times by the top level.
`timescale 1ns / 1ps
`default_nettype none

module ctot_edge
  import ctot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire ctot_stage_en_t               en,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic        [R2_BITS-1:0]    r2,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  input  wire logic signed [COORD_BITS-1:0] qx,
  input  wire logic signed [COORD_BITS-1:0] qy,
  output logic                              vin,
  output logic                              nonneg,
  output logic                              edge_ok
);

  localparam int DW  = COORD_BITS + 1;      // coordinate differences
  localparam int PW  = 2 * DW;              // products of differences
  localparam int SW  = PW + 1;              // sums of two products
  localparam int H   = COORD_BITS + 2;      // low split of wide terms
  localparam int HIW = SW - H;              // high split of wide terms
  localparam int PHH = 2 * HIW;
  localparam int PHL = HIW + H + 1;
  localparam int PLL = 2 * H;
  localparam int RLH = R2_BITS + HIW;
  localparam int RLL = R2_BITS + H;
  localparam int QW  = (2 * SW > R2_BITS + SW) ? 2 * SW : R2_BITS + SW;

  // stage 1: offsets
  logic signed [DW-1:0] dx1, dy1, ex1, ey1;
  // stage 2: products
  logic signed [PW-1:0] dxdx2, dydy2, dxex2, dyey2, eydx2, exdy2, exex2, eyey2;
  // stage 3: sums and flags
  logic signed [SW-1:0] cross3, len3, dist3, dot3;
  logic                 vin3, nonneg3, proj3;
  logic signed [SW-1:0] cross3_r, len3_r;
  logic                 vin3_r, nonneg3_r, proj3_r;
  // stage 4: partial products
  logic signed [HIW-1:0] cr_hi;
  logic        [H-1:0]   cr_lo;
  logic        [HIW-1:0] len_hi;
  logic        [H-1:0]   len_lo;
  logic signed [PHH-1:0] pp_hh4;
  logic signed [PHL-1:0] pp_hl4;
  logic        [PLL-1:0] pp_ll4;
  logic        [RLH-1:0] rl_h4;
  logic        [RLL-1:0] rl_l4;
  logic                  vin4, nonneg4, proj4;
  // stage 5: assembled squares
  logic [QW-1:0] cr2_5, rl5;
  logic          proj5;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx1 <= DW'(center_x) - DW'(px);
      dy1 <= DW'(center_y) - DW'(py);
      ex1 <= DW'(qx) - DW'(px);
      ey1 <= DW'(qy) - DW'(py);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      dxdx2 <= PW'(dx1) * PW'(dx1);
      dydy2 <= PW'(dy1) * PW'(dy1);
      dxex2 <= PW'(dx1) * PW'(ex1);
      dyey2 <= PW'(dy1) * PW'(ey1);
      eydx2 <= PW'(ey1) * PW'(dx1);
      exdy2 <= PW'(ex1) * PW'(dy1);
      exex2 <= PW'(ex1) * PW'(ex1);
      eyey2 <= PW'(ey1) * PW'(ey1);
    end
  end

  always_comb begin
    dist3   = SW'(dxdx2) + SW'(dydy2);
    dot3    = SW'(dxex2) + SW'(dyey2);
    len3    = SW'(exex2) + SW'(eyey2);
    cross3  = SW'(eydx2) - SW'(exdy2);
    vin3    = QW'(unsigned'(dist3)) <= QW'(r2);
    nonneg3 = !cross3[SW-1];
    // projection strictly inside the edge: 0 < dot < squared length
    proj3   = !dot3[SW-1] && (dot3 != {SW{1'b0}}) && (dot3 < len3);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      cross3_r  <= cross3;
      len3_r    <= len3;
      vin3_r    <= vin3;
      nonneg3_r <= nonneg3;
      proj3_r   <= proj3;
    end
  end

  always_comb begin
    cr_hi  = cross3_r[SW-1:H];
    cr_lo  = cross3_r[H-1:0];
    len_hi = len3_r[SW-1:H];
    len_lo = len3_r[H-1:0];
  end

  // split both squares into narrow partial products
  always_ff @(posedge clk) begin
    if (en.s4) begin
      pp_hh4  <= PHH'(cr_hi) * PHH'(cr_hi);
      pp_hl4  <= PHL'(cr_hi) * PHL'($signed({1'b0, cr_lo}));
      pp_ll4  <= PLL'(cr_lo) * PLL'(cr_lo);
      rl_h4   <= RLH'(r2) * RLH'(len_hi);
      rl_l4   <= RLL'(r2) * RLL'(len_lo);
      vin4    <= vin3_r;
      nonneg4 <= nonneg3_r;
      proj4   <= proj3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      cr2_5  <= (QW'(pp_hh4) << (2 * H)) + (QW'(pp_hl4) << (H + 1)) + QW'(pp_ll4);
      rl5    <= (QW'(rl_h4) << H) + QW'(rl_l4);
      vin    <= vin4;
      nonneg <= nonneg4;
      proj5  <= proj4;
    end
  end

  assign edge_ok = proj5 && (cr2_5 <= rl5);

endmodule

`default_nettype wire

FILE: src/ctot_checker.sv
// Port-level checks for the overlap test top level, attached by bind.
// Depends on ctot_pkg and circle_triangle_overlap_test_top.
`timescale 1ns / 1ps
`default_nettype none

module ctot_checker
  import ctot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CFG_W      = COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [COORD_BITS-1:0] in_ax,
  input wire logic [COORD_BITS-1:0] in_ay,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_hit,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_W-1:0]      cfg_data
);

  logic [COORD_BITS-1:0] cx_m, cy_m;
  logic                  in_xfer, at_centre;

  // mirror the centre from the write channel
  always_ff @(posedge clk) begin
    if (rst) begin
      cx_m <= '0;
      cy_m <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CENTER_X) begin
        cx_m <= cfg_data[COORD_BITS-1:0];
      end
      if (cfg_index == CFG_CENTER_Y) begin
        cy_m <= cfg_data[COORD_BITS-1:0];
      end
    end
  end

  assign in_xfer   = in_valid && in_ready;
  assign at_centre = (in_ax == cx_m) && (in_ay == cy_m);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result missing six cycles after transfer");

  a_vertex_on_centre: assert property (@(posedge clk) disable iff (rst)
    in_xfer && at_centre ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready |=> out_valid && out_hit)
    else $error("vertex on the centre gave no hit");

endmodule

bind circle_triangle_overlap_test_top ctot_checker #(
  .COORD_BITS (COORD_BITS),
  .CFG_W      ($bits(cfg.data))
) u_ctot_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (triangle.valid),
  .in_ready  (triangle.ready),
  .in_ax     (triangle.vertex_a_x),
  .in_ay     (triangle.vertex_a_y),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hit   (result.hit),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_index (cfg.index),
  .cfg_data  (cfg.data)
);

`default_nettype wire

FILE: bench/ctot_overlap_checker.sv
// Checker for the circle / triangle overlap test: watches the triangle, result and cfg channels,
// predicts the hit flag for each triangle transfer and compares it with the result stream.
// Depends on ctot_pkg and the channel interfaces in ctot_if.
`timescale 1ns / 1ps

module ctot_overlap_checker
  import ctot_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ctot_tri_if  triangle,
  ctot_hit_if  result,
  ctot_cfg_if  cfg,
  output int   errors,
  output int   outstanding
);

  typedef logic signed [127:0] wide_t;

  logic signed [COORD_BITS_DEF-1:0] circ_x;
  logic signed [COORD_BITS_DEF-1:0] circ_y;
  logic [RADIUS_BITS-1:0]           circ_r;
  bit                               pending_hits [$];
  int                               result_no;

  // Exact squared-integer overlap test; edges run A->B, B->C, C->A.
  function automatic bit circle_touches_triangle(
    input logic signed [COORD_BITS_DEF-1:0] ox, oy,
    input logic [RADIUS_BITS-1:0]           rad,
    input logic signed [COORD_BITS_DEF-1:0] ax, ay, bx, by, cx, cy
  );
    longint px [3];
    longint py [3];
    longint rl;
    wide_t  wdx, wdy, wex, wey, r2, s, k, len2, cr;
    bit     near_hit;
    bit     centre_inside;
    int     i, j;
    px[0] = longint'(ax); py[0] = longint'(ay);
    px[1] = longint'(bx); py[1] = longint'(by);
    px[2] = longint'(cx); py[2] = longint'(cy);
    rl = longint'(rad);
    r2 = wide_t'(rl) * wide_t'(rl);
    near_hit = 1'b0;
    centre_inside = 1'b1;
    for (i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      wdx = wide_t'(longint'(ox) - px[i]);
      wdy = wide_t'(longint'(oy) - py[i]);
      wex = wide_t'(px[j] - px[i]);
      wey = wide_t'(py[j] - py[i]);
      if (wdx * wdx + wdy * wdy <= r2) near_hit = 1'b1;
      s = wey * wdx - wex * wdy;
      if (s < wide_t'(0)) centre_inside = 1'b0;
      // projection strictly inside the edge and perpendicular distance within the radius
      k    = wdx * wex + wdy * wey;
      len2 = wex * wex + wey * wey;
      cr   = wex * wdy - wey * wdx;
      if (k > wide_t'(0) && k < len2 && cr * cr <= r2 * len2) near_hit = 1'b1;
    end
    return near_hit || centre_inside;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      pending_hits.delete();
      circ_x      = '0;
      circ_y      = '0;
      circ_r      = '0;
      result_no   = 0;
      errors      = 0;
      outstanding <= 0;
    end else begin
      if (triangle.valid && triangle.ready)
        pending_hits.push_back(circle_touches_triangle(circ_x, circ_y, circ_r,
          triangle.vertex_a_x, triangle.vertex_a_y, triangle.vertex_b_x,
          triangle.vertex_b_y, triangle.vertex_c_x, triangle.vertex_c_y));
      if (result.valid && result.ready) begin
        if (pending_hits.size() == 0) begin
          report($sformatf("result %0d arrived with no triangle waiting", result_no));
        end else begin
          want = pending_hits.pop_front();
          if (result.hit !== want)
            report($sformatf("result %0d: hit %b, predicted %b", result_no, result.hit, want));
        end
        result_no++;
      end
      // the circle only changes while the pipe is empty, so apply it after the transfers
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CENTER_X: circ_x = cfg.data;
          CFG_CENTER_Y: circ_y = cfg.data;
          CFG_RADIUS:   circ_r = cfg.data[RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      outstanding <= pending_hits.size();
    end
  end

endmodule

FILE: bench/circle_triangle_overlap_test_top_tb.sv
// Testbench top for circle_triangle_overlap_test_top: clock, reset, circle settings and
// triangle stimulus with random gaps and result stalls; ctot_overlap_checker does the comparing.
// Depends on ctot_pkg, ctot_if, the block under test and ctot_overlap_checker.
`timescale 1ns / 1ps

module circle_triangle_overlap_test_top_tb;
  import ctot_pkg::*;

  localparam int CW             = COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 225;
  localparam int DIRECTED_ITEMS = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {SHAPE_WIDE, SHAPE_NEAR, SHAPE_CLOSE, SHAPE_CORNER} shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int   errors;
  int   outstanding;
  int   idle_cycles;
  int   hold_left;
  int   cur_cx, cur_cy, cur_r;

  // vertex sets: at the centre, full-range both windings, centre on an edge,
  // point triangle, repeated vertex, collinear, alternating bits
  int directed_xy [DIRECTED_ITEMS][6] = '{
    '{0, 0, 0, 0, 0, 0},
    '{-32768, -32768, 32767, -32768, 32767, 32767},
    '{32767, 32767, 32767, -32768, -32768, -32768},
    '{-256, 0, 256, 0, 0, 512},
    '{100, 100, 100, 100, 100, 100},
    '{-300, -300, -300, -300, 400, -50},
    '{-10, 0, 10, 0, 20, 0},
    '{21845, -21846, -21846, 21845, -1, 32767}
  };

  ctot_tri_if #(.COORD_BITS(CW)) triangle ();
  ctot_hit_if                    result ();
  ctot_cfg_if #(.DATA_W(CW))     cfg ();

  circle_triangle_overlap_test_top #(.COORD_BITS(CW)) u_top (
    .clk      (clk),
    .rst      (rst),
    .triangle (triangle),
    .result   (result),
    .cfg      (cfg)
  );

  ctot_overlap_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .triangle    (triangle),
    .result      (result),
    .cfg         (cfg),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CW-1:0] pick_coord(input shape_t shape, input int base);
    int span;
    span = 2 * cur_r + 4;
    case (shape)
      SHAPE_NEAR:  return CW'(base + int'($urandom_range(0, 2 * span)) - span);
      SHAPE_CLOSE: return CW'(base + int'($urandom_range(0, 6)) - 3);
      SHAPE_CORNER: begin
        case ($urandom_range(0, 5))
          0: return CW'(-32768);
          1: return CW'(32767);
          2: return CW'(-1);
          3: return CW'(0);
          4: return CW'(1);
          default: return CW'(base);
        endcase
      end
      default: return CW'($urandom);
    endcase
  endfunction

  // result side: random stall runs, held high during steady phases
  always @(posedge clk) begin
    int n;
    if (rst) begin
      result.ready <= 1'b0;
      hold_left    <= 0;
    end else if (steady) begin
      result.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (result.ready) begin
      n = gap_len();
      if (n != 0) begin
        result.ready <= 1'b0;
        hold_left    <= n - 1;
      end
    end else begin
      result.ready <= 1'b1;
      hold_left    <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (rst || (triangle.valid && triangle.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic configure(input int cx, input int cy, input int r, input bit poke_unused);
    if (poke_unused) write_reg(CFG_UNUSED, CW'($urandom));
    write_reg(CFG_CENTER_X, CW'(cx));
    write_reg(CFG_CENTER_Y, CW'(cy));
    write_reg(CFG_RADIUS, CW'(r));
    cfg.valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_r  = r & 32'h7fff;
  endtask

  task automatic send_triangle(input logic [CW-1:0] ax, ay, bx, by, cx, cy);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      triangle.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    triangle.valid      <= 1'b1;
    triangle.vertex_a_x <= ax;
    triangle.vertex_a_y <= ay;
    triangle.vertex_b_x <= bx;
    triangle.vertex_b_y <= by;
    triangle.vertex_c_x <= cx;
    triangle.vertex_c_y <= cy;
    do @(posedge clk); while (!triangle.ready);
  endtask

  // drop valid and hold until every predicted hit has come back
  task automatic drain();
    triangle.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic int pick_centre();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  initial begin
    int p, k, i, r;
    shape_t shape;
    logic [CW-1:0] v [6];
    triangle.valid      <= 1'b0;
    triangle.vertex_a_x <= '0;
    triangle.vertex_a_y <= '0;
    triangle.vertex_b_x <= '0;
    triangle.vertex_b_y <= '0;
    triangle.vertex_c_x <= '0;
    triangle.vertex_c_y <= '0;
    cfg.valid           <= 1'b0;
    cfg.index           <= CFG_CENTER_X;
    cfg.data            <= '0;
    cur_cx = 0;
    cur_cy = 0;
    cur_r  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset circle, then the two extreme circles
    for (p = 0; p < 3; p++) begin
      if (p == 1) begin
        drain();
        configure(-32768, 32767, 32767, 1'b0);
      end else if (p == 2) begin
        drain();
        // zero radius with the unused top data bit set
        configure(32767, -32768, 32'h8000, 1'b1);
      end
      for (k = 0; k < DIRECTED_ITEMS; k++)
        send_triangle(CW'(directed_xy[k][0]), CW'(directed_xy[k][1]),
                      CW'(directed_xy[k][2]), CW'(directed_xy[k][3]),
                      CW'(directed_xy[k][4]), CW'(directed_xy[k][5]));
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 3))
        0: r = 0;
        1: r = 32767;
        2: r = $urandom_range(1, 255);
        default: r = $urandom_range(0, 32767);
      endcase
      r = r | ($urandom_range(0, 1) << 15);
      steady <= (p % 3 == 2);
      configure(pick_centre(), pick_centre(), r, p == 4);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        i = $urandom_range(0, 99);
        if (i < 30)      shape = SHAPE_WIDE;
        else if (i < 65) shape = SHAPE_NEAR;
        else if (i < 80) shape = SHAPE_CLOSE;
        else             shape = SHAPE_CORNER;
        for (i = 0; i < 6; i++)
          v[i] = pick_coord(shape, (i % 2 == 1) ? cur_cy : cur_cx);
        send_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ctot_pkg.sv
src/ctot_if.sv
src/ctot_edge.sv
src/circle_triangle_overlap_test_top.sv
src/ctot_checker.sv
bench/ctot_overlap_checker.sv
bench/circle_triangle_overlap_test_top_tb.sv
